[src/ffba_pkg.sv]
// ----------------------------------------------------------------------------
// ffba_pkg
// Shared widths, command and status codes and sequencer states for the
// first-fit block allocator.
// ----------------------------------------------------------------------------
package ffba_pkg;
	localparam int unsigned ADDR_W  = 48;
	localparam int unsigned OFFS_W  = 33;
	localparam int unsigned LEN_W   = 27;
	localparam int unsigned REQ_W   = 32;
	localparam int unsigned CMD_W   = 3;
	localparam int unsigned STAT_W  = 2;
	localparam int unsigned CNT_W   = 7;
	localparam int unsigned HDRC_W  = 12;
	localparam int unsigned CFG_IDX_W = 1;

	localparam logic [CMD_W-1:0] CMD_ALLOC   = 3'd0;
	localparam logic [CMD_W-1:0] CMD_CALLOC  = 3'd1;
	localparam logic [CMD_W-1:0] CMD_FREE    = 3'd2;
	localparam logic [CMD_W-1:0] CMD_REALLOC = 3'd3;
	localparam logic [CMD_W-1:0] CMD_STATS   = 3'd4;

	localparam logic [STAT_W-1:0] ST_OK      = 2'd0;
	localparam logic [STAT_W-1:0] ST_BADSIZE = 2'd1;
	localparam logic [STAT_W-1:0] ST_NOROOM  = 2'd2;
	localparam logic [STAT_W-1:0] ST_UNKNOWN = 2'd3;

	localparam logic [CFG_IDX_W-1:0] REG_HEAP_BASE  = 1'd0;
	localparam logic [CFG_IDX_W-1:0] REG_HEAP_LIMIT = 1'd1;

	typedef enum logic [3:0] {
		S_IDLE,
		S_MUL,
		S_DECIDE,
		S_FIND,
		S_FIND_CHK,
		S_FIT,
		S_FIT_CHK,
		S_APPEND,
		S_FREE_OLD,
		S_DONE
	} state_t;

	typedef struct packed {
		logic [ADDR_W-1:0] result_address;
		logic [STAT_W-1:0] status;
		logic [LEN_W-1:0]  clear_length;
		logic [ADDR_W-1:0] copy_source;
		logic [LEN_W-1:0]  copy_length;
		logic [CNT_W-1:0]  free_block_count;
		logic [OFFS_W-1:0] free_byte_count;
		logic [CNT_W-1:0]  total_block_count;
		logic [OFFS_W-1:0] total_byte_count;
		logic [HDRC_W-1:0] header_byte_count;
	} result_t;

	typedef struct packed {
		logic [CMD_W-1:0]  command;
		logic [REQ_W-1:0]  request_size;
		logic [REQ_W-1:0]  element_count;
		logic [ADDR_W-1:0] address;
	} request_t;
endpackage

[src/ffba_if.sv]
// ----------------------------------------------------------------------------
// ffba_if
// Valid/ready channel carrying one packed payload.
// ----------------------------------------------------------------------------
interface ffba_if #(parameter int unsigned W = 1);
	logic         valid;
	logic         ready;
	logic [W-1:0] data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

[src/ffba_table.sv]
// ----------------------------------------------------------------------------
// ffba_table
// Block table memory: size, start offset and free mark per entry, one
// write port and one registered read port.
// ----------------------------------------------------------------------------
module ffba_table
	import ffba_pkg::*;
#(
	parameter int unsigned DEPTH = 64,
	parameter int unsigned IDX_W = 6
) (
	input  logic              clk,
	input  logic              we,
	input  logic [IDX_W-1:0]  waddr,
	input  logic [LEN_W-1:0]  wsize,
	input  logic [OFFS_W-1:0] wstart,
	input  logic              wfree,
	input  logic [IDX_W-1:0]  raddr,
	output logic [LEN_W-1:0]  rsize,
	output logic [OFFS_W-1:0] rstart,
	output logic              rfree
);
	logic [LEN_W+OFFS_W:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= {wsize, wstart, wfree};
		end
		{rsize, rstart, rfree} <= mem[raddr];
	end
endmodule

[src/ffba_mul.sv]
// ----------------------------------------------------------------------------
// ffba_mul
// Shift-add multiplier for the zeroed allocate size, four bits a cycle.
// ----------------------------------------------------------------------------
module ffba_mul
	import ffba_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	input  logic [REQ_W-1:0]   a,
	input  logic [REQ_W-1:0]   b,
	output logic               done,
	output logic [2*REQ_W-1:0] product
);
	logic [REQ_W-1:0]   mplr_q;
	logic [2*REQ_W-1:0] mcand_q;
	logic [2*REQ_W-1:0] acc_q;
	logic [3:0]         step_q;
	logic               busy_q;
	logic [2*REQ_W-1:0] add;

	always_comb begin
		add = '0;
		for (int k = 0; k < 4; k++) begin
			if (mplr_q[k]) begin
				add = add + (mcand_q << k);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			step_q <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			step_q <= '0;
		end else if (busy_q) begin
			step_q <= step_q + 4'd1;
			if (step_q == 4'd7) begin
				busy_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			mplr_q  <= a;
			mcand_q <= {{REQ_W{1'b0}}, b};
			acc_q   <= '0;
		end else if (busy_q) begin
			acc_q   <= acc_q + add;
			mplr_q  <= mplr_q >> 4;
			mcand_q <= mcand_q << 4;
		end
	end

	assign done    = busy_q && (step_q == 4'd7);
	assign product = acc_q + add;
endmodule

[src/first_fit_block_allocator_top.sv]
// ----------------------------------------------------------------------------
// first_fit_block_allocator_top
// First-fit heap block allocator with a 64-entry block table.
//
// Requests come in on req (valid/ready), results leave on rsp. One request
// is taken at a time; ready stays low until its result has been taken.
// Both table scans, the address match and the first fit, check one entry at
// a time, each in a read state and a check state. A moving reallocate runs
// both scans, allocate only the first fit, and zeroed allocate first runs
// the serial multiply. Statistics queries skip the scans. The shared
// table read port sets the scan rate. The config port (cfg_we, cfg_index,
// cfg_data) must be written only while idle; the block does not enforce it.
// Reset empties the table by clearing the entry count; heap_base returns to
// 4096 and heap_limit to its maximum. A stalled result is held in its
// output register until taken.
// ----------------------------------------------------------------------------
module first_fit_block_allocator_top
	import ffba_pkg::*;
#(
	parameter int unsigned MAX_BLOCKS   = 64,
	parameter int unsigned HEADER_BYTES = 32,
	parameter int unsigned MAX_REQUEST  = 100000000
) (
	input  logic                 clk,
	input  logic                 arst_n,
	ffba_if.sink                 req,
	ffba_if.source               rsp,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [ADDR_W-1:0]    cfg_data
);
	localparam int unsigned IDX_W = (MAX_BLOCKS > 1) ? $clog2(MAX_BLOCKS) : 1;
	localparam int unsigned CW    = $clog2(MAX_BLOCKS + 1);
	localparam logic [CW-1:0] MAXB = CW'(MAX_BLOCKS);
	localparam logic [63:0] MAXREQ = 64'(MAX_REQUEST);
	localparam logic [ADDR_W-1:0] HDR48 = ADDR_W'(HEADER_BYTES);

	state_t state_q, state_d;

	logic [ADDR_W-1:0] base_q;
	logic [OFFS_W-1:0] limit_q;
	logic [CW-1:0]     count_q;
	logic [OFFS_W-1:0] heap_end_q;
	logic [CW-1:0]     free_blocks_q;
	logic [OFFS_W-1:0] free_bytes_q;
	logic [OFFS_W-1:0] all_bytes_q;

	request_t          req_in;
	request_t          req_q;
	logic [63:0]       size_q;
	logic [CW-1:0]     idx_q;
	logic [IDX_W-1:0]  old_idx_q;
	logic [LEN_W-1:0]  old_size_q;
	logic [OFFS_W-1:0] old_start_q;
	logic              old_free_q;
	logic [LEN_W-1:0]  copy_len_q;
	logic [ADDR_W-1:0] copy_src_q;
	logic [ADDR_W-1:0] res_q;
	logic [STAT_W-1:0] stat_q;
	logic              rsp_valid_q;
	result_t           rsp_q;

	logic              t_we;
	logic [IDX_W-1:0]  t_waddr, t_raddr;
	logic [LEN_W-1:0]  t_wsize, t_rsize;
	logic [OFFS_W-1:0] t_wstart, t_rstart;
	logic              t_wfree, t_rfree;

	logic              mul_start, mul_done;
	logic [63:0]       mul_prod;

	logic [ADDR_W-1:0] entry_addr;
	logic [OFFS_W+1:0] need;
	logic              size_valid;

	ffba_table #(.DEPTH(MAX_BLOCKS), .IDX_W(IDX_W)) u_table (
		.clk(clk), .we(t_we), .waddr(t_waddr), .wsize(t_wsize),
		.wstart(t_wstart), .wfree(t_wfree), .raddr(t_raddr),
		.rsize(t_rsize), .rstart(t_rstart), .rfree(t_rfree)
	);

	ffba_mul u_mul (
		.clk(clk), .arst_n(arst_n), .start(mul_start),
		.a(req_q.element_count), .b(req_q.request_size),
		.done(mul_done), .product(mul_prod)
	);

	assign req_in     = req.data;
	assign entry_addr = base_q + ADDR_W'(t_rstart) + HDR48;
	assign need       = (OFFS_W+2)'(heap_end_q) + (OFFS_W+2)'(HEADER_BYTES)
		+ (OFFS_W+2)'(size_q[LEN_W-1:0]);
	assign size_valid = (size_q != 64'd0) && (size_q <= MAXREQ);
	assign t_raddr    = idx_q[IDX_W-1:0];
	assign mul_start  = (state_q == S_MUL) && (idx_q == '0);
	assign req.ready  = (state_q == S_IDLE) && !rsp_valid_q;
	assign rsp.valid  = rsp_valid_q;
	assign rsp.data   = rsp_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d  = state_q;
		t_we     = 1'b0;
		t_waddr  = old_idx_q;
		t_wsize  = size_q[LEN_W-1:0];
		t_wstart = heap_end_q;
		t_wfree  = 1'b0;
		unique case (state_q)
			S_IDLE: begin
				if (req.valid && req.ready) begin
					state_d = (req_in.command == CMD_CALLOC) ? S_MUL : S_DECIDE;
				end
			end
			S_MUL: begin
				if (mul_done) begin
					state_d = S_DECIDE;
				end
			end
			S_DECIDE: begin
				unique case (req_q.command)
					CMD_ALLOC, CMD_CALLOC: begin
						state_d = size_valid ? S_FIT : S_DONE;
					end
					CMD_FREE: begin
						state_d = (req_q.address == '0) ? S_DONE : S_FIND;
					end
					CMD_REALLOC: begin
						if (!size_valid) begin
							state_d = S_DONE;
						end else if (req_q.address == '0) begin
							state_d = S_FIT;
						end else begin
							state_d = S_FIND;
						end
					end
					default: state_d = S_DONE;
				endcase
			end
			S_FIND: begin
				state_d = (idx_q >= count_q) ? S_DONE : S_FIND_CHK;
			end
			S_FIND_CHK: begin
				if (entry_addr == req_q.address) begin
					if (req_q.command == CMD_FREE) begin
						state_d = S_FREE_OLD;
					end else if (64'(t_rsize) >= size_q) begin
						state_d = S_DONE;
					end else begin
						state_d = S_FIT;
					end
				end else begin
					state_d = S_FIND;
				end
			end
			S_FIT: begin
				state_d = (idx_q >= count_q) ? S_APPEND : S_FIT_CHK;
			end
			S_FIT_CHK: begin
				if (t_rfree && (64'(t_rsize) >= size_q)) begin
					t_we    = 1'b1;
					t_waddr = idx_q[IDX_W-1:0];
					t_wsize = t_rsize;
					t_wstart = t_rstart;
					t_wfree = 1'b0;
					state_d = (req_q.command == CMD_REALLOC && req_q.address != '0)
						? S_FREE_OLD : S_DONE;
				end else begin
					state_d = S_FIT;
				end
			end
			S_APPEND: begin
				if (count_q >= MAXB || need > (OFFS_W+2)'(limit_q)) begin
					state_d = S_DONE;
				end else begin
					t_we    = 1'b1;
					t_waddr = count_q[IDX_W-1:0];
					state_d = (req_q.command == CMD_REALLOC && req_q.address != '0)
						? S_FREE_OLD : S_DONE;
				end
			end
			S_FREE_OLD: begin
				t_we     = 1'b1;
				t_waddr  = old_idx_q;
				t_wsize  = old_size_q;
				t_wstart = old_start_q;
				t_wfree  = 1'b1;
				state_d  = S_DONE;
			end
			S_DONE: begin
				state_d = S_IDLE;
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			base_q        <= ADDR_W'(4096);
			limit_q       <= '1;
			count_q       <= '0;
			heap_end_q    <= '0;
			free_blocks_q <= '0;
			free_bytes_q  <= '0;
			all_bytes_q   <= '0;
			rsp_valid_q   <= 1'b0;
		end else begin
			if (cfg_we) begin
				unique case (cfg_index)
					REG_HEAP_BASE:  base_q  <= cfg_data;
					REG_HEAP_LIMIT: limit_q <= cfg_data[OFFS_W-1:0];
					default: ;
				endcase
			end
			if (rsp.valid && rsp.ready) begin
				rsp_valid_q <= 1'b0;
			end
			if (state_q == S_DONE) begin
				rsp_valid_q <= 1'b1;
			end
			if (state_q == S_FIT_CHK && t_rfree && (64'(t_rsize) >= size_q)) begin
				free_blocks_q <= free_blocks_q - CW'(1);
				free_bytes_q  <= free_bytes_q - OFFS_W'(t_rsize);
			end
			if (state_q == S_APPEND && t_we) begin
				count_q     <= count_q + CW'(1);
				heap_end_q  <= need[OFFS_W-1:0];
				all_bytes_q <= all_bytes_q + OFFS_W'(size_q[LEN_W-1:0]);
			end
			if (state_q == S_FREE_OLD && !old_free_q) begin
				free_blocks_q <= free_blocks_q + CW'(1);
				free_bytes_q  <= free_bytes_q + OFFS_W'(old_size_q);
			end
		end
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			S_IDLE: begin
				req_q      <= req_in;
				size_q     <= 64'(req_in.request_size);
				idx_q      <= '0;
				res_q      <= '0;
				stat_q     <= ST_OK;
				copy_len_q <= '0;
				copy_src_q <= '0;
			end
			S_MUL: begin
				if (mul_done) begin
					size_q <= mul_prod;
				end
			end
			S_DECIDE: begin
				idx_q <= '0;
				if ((req_q.command == CMD_ALLOC || req_q.command == CMD_CALLOC
					|| req_q.command == CMD_REALLOC) && !size_valid) begin
					stat_q <= ST_BADSIZE;
				end
			end
			S_FIND: begin
				if (idx_q >= count_q) begin
					stat_q <= ST_UNKNOWN;
				end
			end
			S_FIND_CHK: begin
				old_idx_q   <= idx_q[IDX_W-1:0];
				old_size_q  <= t_rsize;
				old_start_q <= t_rstart;
				old_free_q  <= t_rfree;
				if (entry_addr == req_q.address) begin
					if (req_q.command == CMD_REALLOC && 64'(t_rsize) >= size_q) begin
						res_q <= req_q.address;
					end
					idx_q <= '0;
				end else begin
					idx_q <= idx_q + CW'(1);
				end
			end
			S_FIT_CHK: begin
				if (t_rfree && (64'(t_rsize) >= size_q)) begin
					res_q <= entry_addr;
					if (req_q.command == CMD_REALLOC && req_q.address != '0) begin
						copy_src_q <= req_q.address;
						copy_len_q <= old_size_q;
					end
				end else begin
					idx_q <= idx_q + CW'(1);
				end
			end
			S_APPEND: begin
				if (count_q >= MAXB || need > (OFFS_W+2)'(limit_q)) begin
					stat_q <= ST_NOROOM;
				end else begin
					res_q <= base_q + ADDR_W'(heap_end_q) + HDR48;
					if (req_q.command == CMD_REALLOC && req_q.address != '0) begin
						copy_src_q <= req_q.address;
						copy_len_q <= old_size_q;
					end
				end
			end
			S_FREE_OLD: ;
			S_FIT, S_DONE: ;
			default: ;
		endcase
		if (state_q == S_MUL && idx_q == '0) begin
			idx_q <= CW'(1);
		end
		if (state_q == S_DONE) begin
			rsp_q.result_address    <= res_q;
			rsp_q.status            <= stat_q;
			rsp_q.clear_length      <= (req_q.command == CMD_CALLOC && stat_q == ST_OK)
				? size_q[LEN_W-1:0] : '0;
			rsp_q.copy_source       <= copy_src_q;
			rsp_q.copy_length       <= copy_len_q;
			rsp_q.free_block_count  <= CNT_W'(free_blocks_q);
			rsp_q.free_byte_count   <= free_bytes_q;
			rsp_q.total_block_count <= CNT_W'(count_q);
			rsp_q.total_byte_count  <= all_bytes_q;
			rsp_q.header_byte_count <= HDRC_W'(32'(count_q) * HEADER_BYTES);
		end
	end

	a_ready_idle: assert property (@(posedge clk) disable iff (!arst_n)
		req.ready |-> (state_q == S_IDLE)) else $error("ready outside idle");
	a_count_max: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= MAXB) else $error("entry count overflow");
	a_free_le_total: assert property (@(posedge clk) disable iff (!arst_n)
		free_blocks_q <= count_q) else $error("free blocks exceed total");
	a_done_valid: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_DONE) |=> rsp_valid_q) else $error("result not presented");
endmodule

[dv/first_fit_block_allocator_top_tb.sv]
// ----------------------------------------------------------------------------
// first_fit_block_allocator_top_tb
// Self-checking bench for the first-fit block allocator. Requests are driven
// on a valid/ready channel with random gaps, and results are taken with
// random stalls. A shadow block table predicts each result, which is then
// compared field by field. Heap base and limit are changed between phases,
// including their extremes.
// ----------------------------------------------------------------------------
module first_fit_block_allocator_top_tb;
	import ffba_pkg::*;

	localparam int unsigned TABLE_DEPTH = 64;
	localparam int unsigned HDR_BYTES   = 32;
	localparam longint unsigned REQ_MAX = 100000000;
	localparam int unsigned IDLE_LIMIT  = 6000;
	localparam int unsigned DRAIN_WAIT  = 300;
	localparam logic [ADDR_W-1:0] ADDR_ONES = '1;

	logic                 clk;
	logic                 arst_n;
	logic                 cfg_we;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [ADDR_W-1:0]    cfg_data;

	ffba_if #(.W($bits(request_t))) req_if ();
	ffba_if #(.W($bits(result_t)))  rsp_if ();

	first_fit_block_allocator_top DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.req       (req_if),
		.rsp       (rsp_if),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	// shadow allocator state
	logic [ADDR_W-1:0] base_addr;
	logic [OFFS_W-1:0] limit_bytes;
	logic [LEN_W-1:0]  blk_size [TABLE_DEPTH];
	logic [OFFS_W-1:0] blk_start [TABLE_DEPTH];
	logic              blk_free [TABLE_DEPTH];
	int unsigned       blk_count;
	logic [OFFS_W-1:0] heap_top;
	int unsigned       free_blk_total;
	logic [OFFS_W-1:0] free_byte_total;
	logic [OFFS_W-1:0] byte_total;

	request_t    request_queue[$];
	result_t     expected_results[$];
	request_t    in_flight;
	int unsigned gap_left;
	int unsigned stall_left;
	bit          no_idle;
	int unsigned mismatches;
	int unsigned requests_sent;
	int unsigned results_seen;
	int unsigned status_seen [4];
	int unsigned idle_cycles;
	int unsigned cfg_writes;

	function automatic logic [ADDR_W-1:0] entry_address(int unsigned i);
		return base_addr + ADDR_W'(blk_start[i]) + ADDR_W'(HDR_BYTES);
	endfunction

	function automatic bit size_valid(logic [63:0] sz);
		return sz != 0 && sz <= REQ_MAX;
	endfunction

	function automatic int find_block(logic [ADDR_W-1:0] a);
		for (int unsigned i = 0; i < blk_count; i++)
			if (entry_address(i) == a) return int'(i);
		return -1;
	endfunction

	function automatic void release_block(int unsigned i);
		if (!blk_free[i]) begin
			blk_free[i] = 1'b1;
			free_blk_total++;
			free_byte_total += OFFS_W'(blk_size[i]);
		end
	endfunction

	function automatic logic [STAT_W-1:0] allocate_block(logic [63:0] sz,
			output logic [ADDR_W-1:0] granted);
		logic [63:0] need;
		granted = '0;
		for (int unsigned i = 0; i < blk_count; i++) begin
			if (blk_free[i] && 64'(blk_size[i]) >= sz) begin
				blk_free[i] = 1'b0;
				free_blk_total--;
				free_byte_total -= OFFS_W'(blk_size[i]);
				granted = entry_address(i);
				return ST_OK;
			end
		end
		need = 64'(heap_top) + HDR_BYTES + sz;
		if (blk_count >= TABLE_DEPTH || need > 64'(limit_bytes)) return ST_NOROOM;
		blk_size[blk_count] = LEN_W'(sz);
		blk_start[blk_count] = heap_top;
		blk_free[blk_count] = 1'b0;
		granted = entry_address(blk_count);
		blk_count++;
		heap_top = OFFS_W'(need);
		byte_total += OFFS_W'(sz);
		return ST_OK;
	endfunction

	function automatic result_t serve_request(request_t r);
		result_t     o;
		logic [63:0] sz;
		logic [63:0] product;
		logic [ADDR_W-1:0] granted;
		int          idx;
		o = '0;
		sz = 64'(r.request_size);
		case (r.command)
			CMD_ALLOC: begin
				if (size_valid(sz)) begin
					o.status = allocate_block(sz, granted);
					o.result_address = granted;
				end else begin
					o.status = ST_BADSIZE;
				end
			end
			CMD_CALLOC: begin
				product = 64'(r.element_count) * sz;
				if (size_valid(product)) begin
					o.status = allocate_block(product, granted);
					o.result_address = granted;
					if (o.status == ST_OK) o.clear_length = LEN_W'(product);
				end else begin
					o.status = ST_BADSIZE;
				end
			end
			CMD_FREE: begin
				if (r.address != 0) begin
					idx = find_block(r.address);
					if (idx < 0) o.status = ST_UNKNOWN;
					else release_block(idx);
				end
			end
			CMD_REALLOC: begin
				if (!size_valid(sz)) begin
					o.status = ST_BADSIZE;
				end else if (r.address == 0) begin
					o.status = allocate_block(sz, granted);
					o.result_address = granted;
				end else begin
					idx = find_block(r.address);
					if (idx < 0) begin
						o.status = ST_UNKNOWN;
					end else if (64'(blk_size[idx]) >= sz) begin
						o.result_address = r.address;
					end else begin
						o.status = allocate_block(sz, granted);
						o.result_address = granted;
						if (o.status == ST_OK) begin
							o.copy_source = r.address;
							o.copy_length = blk_size[idx];
							release_block(idx);
						end
					end
				end
			end
			default: ;
		endcase
		o.free_block_count = CNT_W'(free_blk_total);
		o.free_byte_count = free_byte_total;
		o.total_block_count = CNT_W'(blk_count);
		o.total_byte_count = byte_total;
		o.header_byte_count = HDRC_W'(blk_count * HDR_BYTES);
		return o;
	endfunction

	function automatic int unsigned pick_gap();
		int unsigned p;
		p = $urandom_range(99);
		if (no_idle || p < 55) return 0;
		if (p < 90) return $urandom_range(3, 1);
		return $urandom_range(60, 10);
	endfunction

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// request driver
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			req_if.valid <= 1'b0;
			req_if.data <= '0;
			gap_left <= 0;
		end else begin
			if (req_if.valid && req_if.ready) begin
				expected_results.push_back(serve_request(in_flight));
				requests_sent++;
			end
			if (req_if.valid && !req_if.ready) begin
				req_if.valid <= 1'b1;
			end else if (gap_left > 0) begin
				gap_left <= gap_left - 1;
				req_if.valid <= 1'b0;
			end else if (request_queue.size() > 0) begin
				in_flight = request_queue.pop_front();
				req_if.data <= in_flight;
				req_if.valid <= 1'b1;
				gap_left <= pick_gap();
			end else begin
				req_if.valid <= 1'b0;
			end
			if ($urandom_range(59) == 0) no_idle = ~no_idle;
		end
	end

	// result monitor
	always @(posedge clk or negedge arst_n) begin
		result_t got;
		result_t want;
		if (!arst_n) begin
			rsp_if.ready <= 1'b0;
			stall_left <= 0;
		end else begin
			if (rsp_if.valid && rsp_if.ready) begin
				got = rsp_if.data;
				results_seen++;
				status_seen[got.status]++;
				if (expected_results.size() == 0) begin
					mismatches++;
					if (mismatches <= 10)
						$display("unexpected result %p", got);
				end else begin
					want = expected_results.pop_front();
					if (got.result_address !== want.result_address ||
						got.status !== want.status ||
						got.clear_length !== want.clear_length ||
						got.copy_source !== want.copy_source ||
						got.copy_length !== want.copy_length ||
						got.free_block_count !== want.free_block_count ||
						got.free_byte_count !== want.free_byte_count ||
						got.total_block_count !== want.total_block_count ||
						got.total_byte_count !== want.total_byte_count ||
						got.header_byte_count !== want.header_byte_count) begin
						mismatches++;
						if (mismatches <= 10)
							$display("mismatch on result %0d\n  exp %p\n  got %p",
								results_seen, want, got);
					end
				end
			end
			if (stall_left > 0) begin
				stall_left <= stall_left - 1;
				rsp_if.ready <= 1'b0;
			end else begin
				rsp_if.ready <= 1'b1;
				stall_left <= pick_gap();
			end
		end
	end

	// watchdog
	always @(posedge clk) begin
		if ((req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready)) begin
			idle_cycles <= 0;
		end else if (idle_cycles >= IDLE_LIMIT) begin
			$display("watchdog: no progress for %0d cycles", idle_cycles);
			$display("Regression FAIL");
			$finish;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
	end

	task automatic wait_drained();
		while (request_queue.size() > 0 || req_if.valid || expected_results.size() > 0)
			@(negedge clk);
		repeat (DRAIN_WAIT) @(posedge clk);
	endtask

	task automatic write_register(logic [CFG_IDX_W-1:0] idx, logic [ADDR_W-1:0] value);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= value;
		if (idx == REG_HEAP_BASE) base_addr = value;
		else limit_bytes = OFFS_W'(value);
		cfg_writes++;
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	task automatic send(logic [CMD_W-1:0] c, logic [REQ_W-1:0] sz,
			logic [REQ_W-1:0] n, logic [ADDR_W-1:0] a);
		request_t r;
		r.command = c;
		r.request_size = sz;
		r.element_count = n;
		r.address = a;
		while (request_queue.size() > 0) @(posedge clk);
		request_queue.push_back(r);
	endtask

	task automatic send_directed(logic [CMD_W-1:0] c, logic [REQ_W-1:0] sz,
			logic [REQ_W-1:0] n, logic [ADDR_W-1:0] a);
		send(c, sz, n, a);
		while (request_queue.size() > 0 || req_if.valid || expected_results.size() > 0)
			@(negedge clk);
	endtask

	function automatic logic [REQ_W-1:0] random_size();
		int unsigned p;
		p = $urandom_range(99);
		if (p < 78) return $urandom_range(256, 1);
		if (p < 88) return $urandom_range(REQ_MAX, 1);
		if (p < 93) return $urandom();
		case ($urandom_range(3))
			0: return 0;
			1: return REQ_W'(REQ_MAX);
			2: return REQ_W'(REQ_MAX + 1);
			default: return '1;
		endcase
	endfunction

	function automatic logic [ADDR_W-1:0] random_address();
		int unsigned p;
		logic [ADDR_W-1:0] a;
		p = $urandom_range(99);
		if (blk_count > 0 && p < 72) begin
			a = entry_address($urandom_range(blk_count - 1));
			if ($urandom_range(19) == 0) a = a + ADDR_W'(1);
			return a;
		end
		if (p < 82) return '0;
		return ADDR_W'({$urandom(), $urandom()});
	endfunction

	task automatic send_random(int unsigned n);
		int unsigned p;
		logic [REQ_W-1:0] cnt;
		for (int unsigned k = 0; k < n; k++) begin
			p = $urandom_range(99);
			cnt = ($urandom_range(9) == 0) ? $urandom() : $urandom_range(16);
			if (p < 35) send(CMD_ALLOC, random_size(), $urandom(),
				ADDR_W'({$urandom(), $urandom()}));
			else if (p < 45) send(CMD_CALLOC, ($urandom_range(3) == 0) ? random_size() :
				$urandom_range(64, 1), cnt, ADDR_W'({$urandom(), $urandom()}));
			else if (p < 70) send(CMD_FREE, $urandom(), $urandom(), random_address());
			else if (p < 90) send(CMD_REALLOC, random_size(), $urandom(), random_address());
			else send(CMD_W'($urandom_range(2 ** CMD_W - 1, 32'(CMD_STATS))),
				$urandom(), $urandom(), ADDR_W'({$urandom(), $urandom()}));
		end
	endtask

	initial begin
		req_if.valid = 1'b0;
		req_if.data = '0;
		rsp_if.ready = 1'b0;
		cfg_we = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		idle_cycles = 0;
		no_idle = 1'b0;
		mismatches = 0;
		requests_sent = 0;
		results_seen = 0;
		cfg_writes = 0;
		status_seen = '{default: 0};
		base_addr = 48'd4096;
		limit_bytes = '1;
		blk_count = 0;
		heap_top = '0;
		free_blk_total = 0;
		free_byte_total = '0;
		byte_total = '0;
		arst_n = 1'b0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed corners at reset configuration
		send_directed(CMD_ALLOC, 1, 0, 0);
		send_directed(CMD_ALLOC, REQ_W'(REQ_MAX), 0, 0);
		send_directed(CMD_ALLOC, 0, 0, 0);
		send_directed(CMD_ALLOC, REQ_W'(REQ_MAX + 1), 0, 0);
		send_directed(CMD_ALLOC, '1, '1, ADDR_ONES);
		send_directed(CMD_CALLOC, 10, 10, 0);
		send_directed(CMD_CALLOC, 32'h10000, 32'h10000, 0);
		send_directed(CMD_CALLOC, '1, '1, 0);
		send_directed(CMD_CALLOC, 7, 0, 0);
		send_directed(CMD_FREE, 0, 0, 0);
		send_directed(CMD_FREE, 0, 0, entry_address(0));
		send_directed(CMD_FREE, 0, 0, entry_address(0));
		send_directed(CMD_REALLOC, 50, 0, 0);
		send_directed(CMD_REALLOC, 10, 0, entry_address(1));
		send_directed(CMD_REALLOC, 500, 0, entry_address(2));
		send_directed(CMD_REALLOC, 5, 0, ADDR_ONES);
		send_directed(CMD_REALLOC, 0, 0, entry_address(1));
		send_directed(CMD_FREE, 0, 0, ADDR_ONES);
		send_directed(CMD_STATS, '1, '1, ADDR_ONES);
		// unused codes behave as a statistics query
		for (int unsigned c = 32'(CMD_STATS) + 1; c < 2 ** CMD_W; c++)
			send_directed(CMD_W'(c), 0, 0, 0);
		send_directed(CMD_ALLOC, 1, 0, 0);

		send_random(160);
		wait_drained();
		write_register(REG_HEAP_BASE, 48'd1);
		write_register(REG_HEAP_LIMIT, 48'd3000);
		send_random(100);
		wait_drained();
		write_register(REG_HEAP_BASE, ADDR_ONES);
		write_register(REG_HEAP_LIMIT, 48'h1_FFFF_FFFF);
		send_random(130);
		wait_drained();
		write_register(REG_HEAP_BASE, ADDR_W'({$urandom(), $urandom()}) | 48'd1);
		write_register(REG_HEAP_LIMIT, 48'd0);
		send_random(70);
		wait_drained();
		write_register(REG_HEAP_BASE, 48'd4096);
		write_register(REG_HEAP_LIMIT, 48'h1_FFFF_FFFF);
		send_random(70);
		wait_drained();

		$display("%0d requests, %0d results, %0d register writes, %0d blocks in table",
			requests_sent, results_seen, cfg_writes, blk_count);
		$display("status ok %0d, bad size %0d, no room %0d, unknown %0d",
			status_seen[0], status_seen[1], status_seen[2], status_seen[3]);
		if (mismatches == 0 && expected_results.size() == 0) begin
			$display("Regression PASS");
		end else begin
			$display("%0d mismatches", mismatches);
			$display("Regression FAIL");
		end
		$finish;
	end
endmodule

[filelist.f]
src/ffba_pkg.sv
src/ffba_if.sv
src/ffba_table.sv
src/ffba_mul.sv
src/first_fit_block_allocator_top.sv
dv/first_fit_block_allocator_top_tb.sv
